// File: src/ctum_pkg.sv
package ctum_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_ADD_ENTRY = 2'd0,
    CMD_ADD_RANGE = 2'd1,
    CMD_LOOKUP    = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_e;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FOUND = 3'd1;
  localparam logic [2:0] ST_MISS  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;

  localparam logic [2:0] DEFAULT_WIDTH = 3'd2;
  localparam int unsigned IO_POINTS = 4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] code;
    logic [31:0] code_high;
    logic [2:0]  code_bytes;
    logic [2:0]  cp_count;
    logic [20:0] cp0;
    logic [20:0] cp1;
    logic [20:0] cp2;
    logic [20:0] cp3;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  found_count;
    logic [31:0] out_cp0;
    logic [31:0] out_cp1;
    logic [31:0] out_cp2;
    logic [31:0] out_cp3;
    logic [2:0]  seen_width;
    logic [8:0]  stored_count;
  } out_item_t;

  // write side of the entry store
  typedef struct packed {
    logic        code_we;
    logic        pt_we;
    logic [31:0] code;
    logic [2:0]  len;
    logic [20:0] pt;
  } ent_wr_t;

  // write side of the range store
  typedef struct packed {
    logic        we;
    logic [31:0] low;
    logic [31:0] high;
    logic [20:0] start;
  } rng_wr_t;

endpackage

// File: src/ctum_in_if.sv
interface ctum_in_if;
  logic                valid;
  logic                ready;
  ctum_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ctum_out_if.sv
interface ctum_out_if;
  logic                valid;
  logic                ready;
  ctum_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ctum_entry_store.sv
module ctum_entry_store #(
  parameter int unsigned ENTRY_DEPTH = 256,
  parameter int unsigned MAX_POINTS  = 4,
  localparam int unsigned EAW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1,
  localparam int unsigned PD  = ENTRY_DEPTH * MAX_POINTS,
  localparam int unsigned PAW = (PD > 1) ? $clog2(PD) : 1
) (
  input  logic              clk_i,
  input  ctum_pkg::ent_wr_t wr_i,
  input  logic [EAW-1:0]    waddr_i,
  input  logic [PAW-1:0]    pt_waddr_i,
  input  logic [EAW-1:0]    raddr_i,
  input  logic [PAW-1:0]    pt_raddr_i,
  output logic [31:0]       code_o,
  output logic [2:0]        len_o,
  output logic [20:0]       pt_o
);

  logic [31:0] code_mem [ENTRY_DEPTH];
  logic [2:0]  len_mem  [ENTRY_DEPTH];
  logic [20:0] pt_mem   [PD];

  // code and length share one address, points have their own port
  always_ff @(posedge clk_i) begin
    if (wr_i.code_we) begin
      code_mem[waddr_i] <= wr_i.code;
      len_mem[waddr_i]  <= wr_i.len;
    end
    code_o <= code_mem[raddr_i];
    len_o  <= len_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.pt_we) begin
      pt_mem[pt_waddr_i] <= wr_i.pt;
    end
    pt_o <= pt_mem[pt_raddr_i];
  end

endmodule

// File: src/ctum_range_store.sv
module ctum_range_store #(
  parameter int unsigned RANGE_DEPTH = 64,
  localparam int unsigned RAW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1
) (
  input  logic              clk_i,
  input  ctum_pkg::rng_wr_t wr_i,
  input  logic [RAW-1:0]    waddr_i,
  input  logic [RAW-1:0]    raddr_i,
  output logic [31:0]       low_o,
  output logic [31:0]       high_o,
  output logic [20:0]       start_o
);

  logic [31:0] low_mem   [RANGE_DEPTH];
  logic [31:0] high_mem  [RANGE_DEPTH];
  logic [20:0] start_mem [RANGE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      low_mem[waddr_i]   <= wr_i.low;
      high_mem[waddr_i]  <= wr_i.high;
      start_mem[waddr_i] <= wr_i.start;
    end
    low_o   <= low_mem[raddr_i];
    high_o  <= high_mem[raddr_i];
    start_o <= start_mem[raddr_i];
  end

endmodule

// File: src/code_to_unicode_map_table.sv
// Character-code-to-Unicode map table. Each transfer on in_i carries one
// command (add entry, add range, lookup, clear) and yields exactly one result
// transfer on out_o. Entries and ranges live in single-port-read memories that
// a small sequencer walks with one compare per cycle. The block takes one
// command at a time: in_i.ready is high only while the sequencer is idle, but
// a finished result may still sit in the output register while the next
// command is taken. Add entry writes its code points one at a time. A lookup
// scans the entries in insert order and reads out the code points of the
// first hit; with no hit it scans the ranges, then checks the bound of the
// best one and adds the offset. A result waiting in the output register holds
// the sequencer until the register is free. Stores need no clearing: the fill
// counts limit every read to written slots.
module code_to_unicode_map_table #(
  parameter int unsigned ENTRY_DEPTH = 256,
  parameter int unsigned RANGE_DEPTH = 64,
  parameter int unsigned MAX_POINTS  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctum_in_if.sink           in_i,
  ctum_out_if.source        out_o
);

  localparam int unsigned EAW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int unsigned EUW = $clog2(ENTRY_DEPTH + 1);
  localparam int unsigned RAW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
  localparam int unsigned RUW = $clog2(RANGE_DEPTH + 1);
  localparam int unsigned PD  = ENTRY_DEPTH * MAX_POINTS;
  localparam int unsigned PAW = (PD > 1) ? $clog2(PD) : 1;
  // an entry carries at most this many code points
  localparam int unsigned POINT_LIMIT =
    (MAX_POINTS < ctum_pkg::IO_POINTS) ? MAX_POINTS : ctum_pkg::IO_POINTS;

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,  // waiting for an input transfer
    S_EXEC  = 10'b00_0000_0010,  // decode, check and start the command
    S_WPTS  = 10'b00_0000_0100,  // write entry code points, one per cycle
    S_ESCAN = 10'b00_0000_1000,  // entry scan, pipelined over the read port
    S_EPRD  = 10'b00_0001_0000,  // read address for a matched code point
    S_EPCAP = 10'b00_0010_0000,  // capture that code point
    S_RSCAN = 10'b00_0100_0000,  // range scan for greatest low not above code
    S_RRD   = 10'b00_1000_0000,  // read high bound and start of best range
    S_RCHK  = 10'b01_0000_0000,  // bound check and offset add
    S_DONE  = 10'b10_0000_0000   // load the output register
  } state_e;

  state_e state_q, state_d;

  ctum_pkg::in_item_t  in_q, in_d;      // command being worked on
  ctum_pkg::out_item_t res_q, res_d;    // result under construction
  ctum_pkg::out_item_t out_q, out_d;    // output register
  logic                out_vld_q, out_vld_d;

  logic [EUW-1:0] ent_used_q, ent_used_d;
  logic [RUW-1:0] rng_used_q, rng_used_d;
  logic [2:0]     widest_q, widest_d;

  // scan pointers; pend marks that the read port holds data for *pidx
  logic [EUW-1:0] eptr_q, eptr_d;
  logic [EAW-1:0] epidx_q, epidx_d;
  logic [RUW-1:0] rptr_q, rptr_d;
  logic [RAW-1:0] rpidx_q, rpidx_d;
  logic           pend_q, pend_d;

  // best range so far
  logic           have_q, have_d;
  logic [31:0]    best_low_q, best_low_d;
  logic [RAW-1:0] best_idx_q, best_idx_d;

  // code point counter and base address in the point store
  logic [2:0]     k_q, k_d;
  logic [2:0]     len_q, len_d;
  logic [PAW-1:0] pt_base_q, pt_base_d;

  // memory ports
  ctum_pkg::ent_wr_t ent_wr;
  logic [EAW-1:0]    ent_waddr;
  logic [PAW-1:0]    pt_waddr;
  logic [EAW-1:0]    ent_raddr;
  logic [PAW-1:0]    pt_raddr;
  logic [31:0]       ent_code_rd;
  logic [2:0]        ent_len_rd;
  logic [20:0]       ent_pt_rd;

  ctum_pkg::rng_wr_t rng_wr;
  logic [RAW-1:0]    rng_waddr;
  logic [RAW-1:0]    rng_raddr;
  logic [31:0]       rng_low_rd;
  logic [31:0]       rng_high_rd;
  logic [20:0]       rng_start_rd;

  logic [31:0]       stored_sum;
  logic [20:0]       wr_point;
  logic              e_issue;
  logic              r_issue;

  ctum_entry_store #(
    .ENTRY_DEPTH (ENTRY_DEPTH),
    .MAX_POINTS  (MAX_POINTS)
  ) u_entry_store (
    .clk_i      (clk_i),
    .wr_i       (ent_wr),
    .waddr_i    (ent_waddr),
    .pt_waddr_i (pt_waddr),
    .raddr_i    (ent_raddr),
    .pt_raddr_i (pt_raddr),
    .code_o     (ent_code_rd),
    .len_o      (ent_len_rd),
    .pt_o       (ent_pt_rd)
  );

  ctum_range_store #(
    .RANGE_DEPTH (RANGE_DEPTH)
  ) u_range_store (
    .clk_i   (clk_i),
    .wr_i    (rng_wr),
    .waddr_i (rng_waddr),
    .raddr_i (rng_raddr),
    .low_o   (rng_low_rd),
    .high_o  (rng_high_rd),
    .start_o (rng_start_rd)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  assign stored_sum = 32'(ent_used_q) + 32'(rng_used_q);
  assign e_issue    = (eptr_q < ent_used_q);
  assign r_issue    = (rptr_q < rng_used_q);

  // read addresses: entries at the scan pointer; ranges at it while scanning, else the best slot
  assign ent_raddr = eptr_q[EAW-1:0];
  assign pt_raddr  = pt_base_q + PAW'(k_q);
  assign rng_raddr = (state_q == S_RSCAN) ? rptr_q[RAW-1:0] : best_idx_q;

  // code point to store on this pass of the write loop
  always_comb begin
    case (k_q[1:0])
      2'd0:    wr_point = in_q.cp0;
      2'd1:    wr_point = in_q.cp1;
      2'd2:    wr_point = in_q.cp2;
      default: wr_point = in_q.cp3;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    in_d       = in_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    ent_used_d = ent_used_q;
    rng_used_d = rng_used_q;
    widest_d   = widest_q;
    eptr_d     = eptr_q;
    epidx_d    = epidx_q;
    rptr_d     = rptr_q;
    rpidx_d    = rpidx_q;
    pend_d     = pend_q;
    have_d     = have_q;
    best_low_d = best_low_q;
    best_idx_d = best_idx_q;
    k_d        = k_q;
    len_d      = len_q;
    pt_base_d  = pt_base_q;

    ent_wr.code_we = 1'b0;
    ent_wr.pt_we   = 1'b0;
    ent_wr.code    = in_q.code;
    ent_wr.len     = in_q.cp_count;
    ent_wr.pt      = wr_point;
    ent_waddr      = ent_used_q[EAW-1:0];
    pt_waddr       = pt_base_q + PAW'(k_q);

    rng_wr.we    = 1'b0;
    rng_wr.low   = in_q.code;
    rng_wr.high  = in_q.code_high;
    rng_wr.start = in_q.cp0;
    rng_waddr    = rng_used_q[RAW-1:0];

    // result transfer drains the output register
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          in_d    = in_i.data;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d             = '0;
        res_d.status      = ctum_pkg::ST_OK;
        state_d           = S_DONE;
        // inserts track the widest code even when they are then refused
        if ((in_q.cmd == ctum_pkg::CMD_ADD_ENTRY || in_q.cmd == ctum_pkg::CMD_ADD_RANGE)
            && in_q.code_bytes >= 3'd1 && in_q.code_bytes <= 3'd4
            && in_q.code_bytes > widest_q) begin
          widest_d = in_q.code_bytes;
        end
        unique case (ctum_pkg::cmd_e'(in_q.cmd))
          ctum_pkg::CMD_ADD_ENTRY: begin
            if (in_q.cp_count == 3'd0 || in_q.cp_count > 3'(POINT_LIMIT)) begin
              res_d.status = ctum_pkg::ST_BAD;
            end else if (ent_used_q >= EUW'(ENTRY_DEPTH)) begin
              res_d.status = ctum_pkg::ST_FULL;
            end else begin
              ent_wr.code_we = 1'b1;
              k_d            = 3'd0;
              pt_base_d      = PAW'(ent_used_q[EAW-1:0]) * PAW'(MAX_POINTS);
              state_d        = S_WPTS;
            end
          end
          ctum_pkg::CMD_ADD_RANGE: begin
            if (in_q.code_high < in_q.code) begin
              res_d.status = ctum_pkg::ST_BAD;
            end else if (rng_used_q >= RUW'(RANGE_DEPTH)) begin
              res_d.status = ctum_pkg::ST_FULL;
            end else begin
              rng_wr.we  = 1'b1;
              rng_used_d = rng_used_q + RUW'(1);
            end
          end
          ctum_pkg::CMD_LOOKUP: begin
            eptr_d  = '0;
            pend_d  = 1'b0;
            state_d = S_ESCAN;
          end
          ctum_pkg::CMD_CLEAR: begin
            ent_used_d = '0;
            rng_used_d = '0;
            widest_d   = '0;
          end
          default: ;
        endcase
      end

      S_WPTS: begin
        ent_wr.pt_we = 1'b1;
        if (k_q == in_q.cp_count - 3'd1) begin
          ent_used_d = ent_used_q + EUW'(1);
          state_d    = S_DONE;
        end else begin
          k_d = k_q + 3'd1;
        end
      end

      S_ESCAN: begin
        if (pend_q && ent_code_rd == in_q.code) begin
          // first match in insert order wins
          len_d     = ent_len_rd;
          k_d       = 3'd0;
          pt_base_d = PAW'(epidx_q) * PAW'(MAX_POINTS);
          pend_d    = 1'b0;
          state_d   = S_EPRD;
        end else if (!pend_q && !e_issue) begin
          rptr_d  = '0;
          have_d  = 1'b0;
          state_d = S_RSCAN;
        end else begin
          pend_d  = e_issue;
          epidx_d = eptr_q[EAW-1:0];
          if (e_issue) begin
            eptr_d = eptr_q + EUW'(1);
          end
        end
      end

      S_EPRD: begin
        state_d = S_EPCAP;
      end

      S_EPCAP: begin
        case (k_q[1:0])
          2'd0:    res_d.out_cp0 = 32'(ent_pt_rd);
          2'd1:    res_d.out_cp1 = 32'(ent_pt_rd);
          2'd2:    res_d.out_cp2 = 32'(ent_pt_rd);
          default: res_d.out_cp3 = 32'(ent_pt_rd);
        endcase
        if (k_q == len_q - 3'd1) begin
          res_d.status      = ctum_pkg::ST_FOUND;
          res_d.found_count = len_q;
          state_d           = S_DONE;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_EPRD;
        end
      end

      S_RSCAN: begin
        // strict greater keeps the earliest range on equal lows
        if (pend_q && rng_low_rd <= in_q.code && (!have_q || rng_low_rd > best_low_q)) begin
          have_d     = 1'b1;
          best_low_d = rng_low_rd;
          best_idx_d = rpidx_q;
        end
        if (!pend_q && !r_issue) begin
          if (have_q) begin
            state_d = S_RRD;
          end else begin
            res_d.status = ctum_pkg::ST_MISS;
            state_d      = S_DONE;
          end
        end else begin
          pend_d  = r_issue;
          rpidx_d = rptr_q[RAW-1:0];
          if (r_issue) begin
            rptr_d = rptr_q + RUW'(1);
          end
        end
      end

      S_RRD: begin
        state_d = S_RCHK;
      end

      S_RCHK: begin
        if (in_q.code <= rng_high_rd) begin
          res_d.status      = ctum_pkg::ST_FOUND;
          res_d.found_count = 3'd1;
          res_d.out_cp0     = 32'(rng_start_rd) + (in_q.code - best_low_q);
        end else begin
          res_d.status = ctum_pkg::ST_MISS;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // wait for the output register to be free
        if (!out_vld_q || out_o.ready) begin
          out_d              = res_q;
          out_d.seen_width   = (widest_q != 3'd0) ? widest_q : ctum_pkg::DEFAULT_WIDTH;
          out_d.stored_count = stored_sum[8:0];
          out_vld_d          = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_vld_q  <= 1'b0;
      ent_used_q <= '0;
      rng_used_q <= '0;
      widest_q   <= '0;
      eptr_q     <= '0;
      rptr_q     <= '0;
      pend_q     <= 1'b0;
      have_q     <= 1'b0;
      k_q        <= '0;
      len_q      <= '0;
    end else begin
      state_q    <= state_d;
      out_vld_q  <= out_vld_d;
      ent_used_q <= ent_used_d;
      rng_used_q <= rng_used_d;
      widest_q   <= widest_d;
      eptr_q     <= eptr_d;
      rptr_q     <= rptr_d;
      pend_q     <= pend_d;
      have_q     <= have_d;
      k_q        <= k_d;
      len_q      <= len_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    res_q      <= res_d;
    out_q      <= out_d;
    epidx_q    <= epidx_d;
    rpidx_q    <= rpidx_d;
    best_low_q <= best_low_d;
    best_idx_q <= best_idx_d;
    pt_base_q  <= pt_base_d;
  end

endmodule

// File: src/ctum_checker.sv
module ctum_assert (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ctum_pkg::out_item_t out_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result dropped or changed");

  // one command at a time
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again while a command is in work");

  // no result appears right after an input transfer
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result loaded too early");

  // a result that is not a hit carries no code points
  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && $rose(out_valid_i) && out_data_i.status != ctum_pkg::ST_FOUND
    |-> out_data_i.found_count == 3'd0 && out_data_i.out_cp0 == 32'd0)
    else $error("code points on a non-hit result");

endmodule

bind code_to_unicode_map_table ctum_assert u_ctum_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// File: sim/ctum_checker.sv
`timescale 1ns / 1ps

module ctum_checker
  import ctum_pkg::*;
#(
  parameter int unsigned ENTRY_DEPTH = 256,
  parameter int unsigned RANGE_DEPTH = 64,
  parameter int unsigned MAX_POINTS  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctum_in_if          in_mon_i,
  ctum_out_if         out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned POINT_LIMIT = (MAX_POINTS < IO_POINTS) ? MAX_POINTS : IO_POINTS;

  // shadow copy of the table
  logic [31:0] ent_code  [ENTRY_DEPTH];
  logic [2:0]  ent_len   [ENTRY_DEPTH];
  logic [20:0] ent_pts   [ENTRY_DEPTH][IO_POINTS];
  logic [31:0] rng_low   [RANGE_DEPTH];
  logic [31:0] rng_high  [RANGE_DEPTH];
  logic [20:0] rng_start [RANGE_DEPTH];
  int unsigned n_ent;
  int unsigned n_rng;
  logic [2:0]  widest;

  out_item_t   lookup_q [$];
  out_item_t   want;

  function automatic out_item_t map_predict(in_item_t it);
    out_item_t   res;
    logic [31:0] pts [IO_POINTS];
    bit          hit;
    bit          have;
    int unsigned best;
    res  = '0;
    hit  = 1'b0;
    have = 1'b0;
    best = 0;
    for (int k = 0; k < IO_POINTS; k++) pts[k] = '0;

    // inserts track the widest code even when they are then rejected
    if ((it.cmd == CMD_ADD_ENTRY || it.cmd == CMD_ADD_RANGE) &&
        it.code_bytes >= 3'd1 && it.code_bytes <= 3'd4 && it.code_bytes > widest)
      widest = it.code_bytes;

    case (it.cmd)
      CMD_ADD_ENTRY: begin
        if (it.cp_count == 3'd0 || it.cp_count > POINT_LIMIT) begin
          res.status = ST_BAD;
        end else if (n_ent >= ENTRY_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ent_code[n_ent]   = it.code;
          ent_len[n_ent]    = it.cp_count;
          ent_pts[n_ent][0] = it.cp0;
          ent_pts[n_ent][1] = it.cp1;
          ent_pts[n_ent][2] = it.cp2;
          ent_pts[n_ent][3] = it.cp3;
          n_ent++;
          res.status = ST_OK;
        end
      end
      CMD_ADD_RANGE: begin
        if (it.code_high < it.code) begin
          res.status = ST_BAD;
        end else if (n_rng >= RANGE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          rng_low[n_rng]   = it.code;
          rng_high[n_rng]  = it.code_high;
          rng_start[n_rng] = it.cp0;
          n_rng++;
          res.status = ST_OK;
        end
      end
      CMD_LOOKUP: begin
        // exact entry first, earliest insert wins
        for (int i = 0; i < n_ent; i++) begin
          if (!hit && ent_code[i] == it.code) begin
            hit = 1'b1;
            res.found_count = ent_len[i];
            for (int k = 0; k < IO_POINTS; k++)
              if (k < ent_len[i]) pts[k] = {11'd0, ent_pts[i][k]};
          end
        end
        if (!hit) begin
          // greatest low bound not above the code, strict compare keeps the earliest
          for (int i = 0; i < n_rng; i++) begin
            if (rng_low[i] <= it.code && (!have || rng_low[i] > rng_low[best])) begin
              have = 1'b1;
              best = i;
            end
          end
          if (have && it.code <= rng_high[best]) begin
            hit = 1'b1;
            res.found_count = 3'd1;
            pts[0] = {11'd0, rng_start[best]} + (it.code - rng_low[best]);
          end
        end
        res.status = hit ? ST_FOUND : ST_MISS;
      end
      default: begin
        n_ent  = 0;
        n_rng  = 0;
        widest = '0;
        res.status = ST_OK;
      end
    endcase

    res.out_cp0      = pts[0];
    res.out_cp1      = pts[1];
    res.out_cp2      = pts[2];
    res.out_cp3      = pts[3];
    res.seen_width   = (widest != '0) ? widest : DEFAULT_WIDTH;
    res.stored_count = 9'(n_ent + n_rng);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      n_ent        = 0;
      n_rng        = 0;
      widest       = '0;
      fail_count_o = 0;
      lookup_q.delete();
      pending_o   <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (lookup_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          fail_count_o++;
        end else begin
          want = lookup_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_mon_i.data.status));
          check_field("found_count", 32'(want.found_count),
                      32'(out_mon_i.data.found_count));
          check_field("out_cp0",      want.out_cp0,      out_mon_i.data.out_cp0);
          check_field("out_cp1",      want.out_cp1,      out_mon_i.data.out_cp1);
          check_field("out_cp2",      want.out_cp2,      out_mon_i.data.out_cp2);
          check_field("out_cp3",      want.out_cp3,      out_mon_i.data.out_cp3);
          check_field("seen_width", 32'(want.seen_width),
                      32'(out_mon_i.data.seen_width));
          check_field("stored_count", 32'(want.stored_count),
                      32'(out_mon_i.data.stored_count));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        lookup_q.push_back(map_predict(in_mon_i.data));
      pending_o <= lookup_q.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ctum_pkg::*;

  // run length and guard
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned CYCLE_LIMIT  = 1_200_000;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic        clk_i;
  logic        rst_ni;

  ctum_in_if  in_if ();
  ctum_out_if out_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned cycle_cnt;
  int unsigned stall_left;
  int unsigned ready_roll;
  int unsigned rnd_start;
  int unsigned seg_len;
  int unsigned roll;
  bit          calm;

  // codes already used by inserts, so that lookups can aim at them
  logic [31:0] seen_codes [$];

  code_to_unicode_map_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ctum_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side back-pressure: mostly short stalls, a few long ones,
  // no new ones while calm is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 65) begin
        out_if.ready <= 1'b1;
      end else if (ready_roll < 93) begin
        out_if.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 2);
      end else begin
        out_if.ready <= 1'b0;
        stall_left   <= $urandom_range(8, 40);
      end
    end
  end

  function automatic in_item_t make_cmd(cmd_e c, logic [31:0] code, logic [31:0] hi,
                                        logic [2:0] nbytes, logic [2:0] cnt,
                                        logic [20:0] p0, logic [20:0] p1,
                                        logic [20:0] p2, logic [20:0] p3);
    in_item_t it;
    it.cmd        = c;
    it.code       = code;
    it.code_high  = hi;
    it.code_bytes = nbytes;
    it.cp_count   = cnt;
    it.cp0        = p0;
    it.cp1        = p1;
    it.cp2        = p2;
    it.cp3        = p3;
    return it;
  endfunction

  // code values: dense low space for collisions, reused codes, wide and top-end codes
  function automatic logic [31:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 63);
    if (r < 55 && seen_codes.size() != 0)
      return seen_codes[$urandom_range(0, seen_codes.size() - 1)] + $urandom_range(0, 2);
    if (r < 75) return $urandom;
    if (r < 85) return 32'hFFFF_FFFF - $urandom_range(0, 15);
    return $urandom_range(0, 16'hFFFF);
  endfunction

  // mostly real code points, sometimes the whole 21-bit field
  function automatic logic [20:0] pick_point();
    if ($urandom_range(0, 9) < 7) return 21'($urandom_range(0, 21'h10FFFF));
    return 21'($urandom);
  endfunction

  // tidy items are well formed; the rest may carry a bad count or an inverted range
  function automatic in_item_t rand_item(cmd_e c, bit tidy);
    in_item_t    it;
    logic [32:0] hi_w;
    int unsigned r;
    int unsigned span;
    it.cmd        = c;
    it.code       = pick_code();
    it.code_high  = $urandom;
    it.code_bytes = 3'($urandom_range(1, 4));
    if ($urandom_range(0, 9) == 0) it.code_bytes = 3'($urandom_range(0, 7));
    it.cp_count   = 3'($urandom_range(1, 4));
    if (!tidy) begin
      r = $urandom_range(4, 7);
      it.cp_count = (r == 4) ? 3'd0 : 3'(r);
    end
    it.cp0 = pick_point();
    it.cp1 = pick_point();
    it.cp2 = pick_point();
    it.cp3 = pick_point();
    if (c == CMD_ADD_RANGE) begin
      r = $urandom_range(0, 99);
      if (!tidy && it.code != 0) begin
        it.code_high = $urandom_range(0, it.code - 1);
      end else if (r < 10) begin
        it.code_high = 32'hFFFF_FFFF;
      end else begin
        span = (r < 65) ? $urandom_range(0, 16) : $urandom_range(0, 4096);
        hi_w = {1'b0, it.code} + span;
        it.code_high = hi_w[32] ? 32'hFFFF_FFFF : hi_w[31:0];
      end
    end
    if (c == CMD_LOOKUP && seen_codes.size() != 0 && $urandom_range(0, 9) < 6)
      it.code = seen_codes[$urandom_range(0, seen_codes.size() - 1)] + $urandom_range(0, 3);
    return it;
  endfunction

  // one command transfer, with a random gap ahead of it
  task automatic send_cmd(input in_item_t it);
    int unsigned gap;
    int unsigned r;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!calm) begin
      if (r >= 90)      gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    // remember insert codes for later lookups
    if (it.cmd == CMD_ADD_ENTRY || it.cmd == CMD_ADD_RANGE) begin
      seen_codes.push_back(it.code);
      if (it.cmd == CMD_ADD_RANGE) seen_codes.push_back(it.code_high);
      while (seen_codes.size() > 48) void'(seen_codes.pop_front());
    end
    // switch between idling and stretches without any
    if (items_sent % 50 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    items_sent = 0;
    calm       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    // lookup on an empty table, default width
    send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF, 3'd7, 3'd7, '1, '1, '1, '1));
    // top code with four all-ones points, width 0 ignored
    send_cmd(make_cmd(CMD_ADD_ENTRY, 32'hFFFF_FFFF, 32'h0, 3'd0, 3'd4, '1, '1, '1, '1));
    // code 0, width 7 ignored
    send_cmd(make_cmd(CMD_ADD_ENTRY, 32'h0, 32'hFFFF_FFFF, 3'd7, 3'd1, '0, '0, '0, '0));
    // bad point counts, widths still noted
    send_cmd(make_cmd(CMD_ADD_ENTRY, 32'h20, 32'h0, 3'd1, 3'd0, 21'h41, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD_ENTRY, 32'h20, 32'h0, 3'd4, 3'd5, 21'h41, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD_ENTRY, 32'h20, 32'h0, 3'd2, 3'd7, 21'h41, 0, 0, 0));
    // duplicate codes, the earlier one must win
    send_cmd(make_cmd(CMD_ADD_ENTRY, 32'h41, 32'h0, 3'd2, 3'd2, 21'h10FFFF, 21'h1, 0, 0));
    send_cmd(make_cmd(CMD_ADD_ENTRY, 32'h41, 32'h0, 3'd2, 3'd3, 21'h5, 21'h6, 21'h7, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'h41, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    // inverted range
    send_cmd(make_cmd(CMD_ADD_RANGE, 32'h100, 32'hFF, 3'd3, 3'd0, 21'h30, 0, 0, 0));
    // equal lows tie, then a nested range with a higher low
    send_cmd(make_cmd(CMD_ADD_RANGE, 32'h1000, 32'h1FFF, 3'd2, 3'd0, 21'h20, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD_RANGE, 32'h1000, 32'h10FF, 3'd2, 3'd0, 21'h500, 0, 0, 0));
    send_cmd(make_cmd(CMD_ADD_RANGE, 32'h1800, 32'h1810, 3'd2, 3'd0, 21'h0, 0, 0, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'h1005, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    // covered by the wide range but the nearest low bound ends below it
    send_cmd(make_cmd(CMD_LOOKUP, 32'h1900, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    // clear drops everything and the width
    send_cmd(make_cmd(CMD_CLEAR, 32'h41, 32'h0, 3'd4, 3'd4, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'h41, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    // full-span range with top start, offset wraps past 2^32
    send_cmd(make_cmd(CMD_ADD_RANGE, 32'h0, 32'hFFFF_FFFF, 3'd1, 3'd0, '1, 0, 0, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'hFFFF_FFF0, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    // single-code range, and the code just past it
    send_cmd(make_cmd(CMD_ADD_RANGE, 32'h5, 32'h5, 3'd5, 3'd0, 21'h1234, 0, 0, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'h5, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'h6, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_CLEAR, 32'h0, 32'h0, 3'd0, 3'd0, 0, 0, 0, 0));

    // random part
    rnd_start = items_sent;

    // fill both stores past full, probing along the way
    for (int i = 0; i < 260; i++) begin
      send_cmd(rand_item(CMD_ADD_ENTRY, 1'b1));
      if (i % 16 == 15) send_cmd(rand_item(CMD_LOOKUP, 1'b1));
    end
    for (int i = 0; i < 67; i++) begin
      send_cmd(rand_item(CMD_ADD_RANGE, 1'b1));
      if (i % 8 == 7) send_cmd(rand_item(CMD_LOOKUP, 1'b1));
    end
    repeat (12) send_cmd(rand_item(CMD_LOOKUP, 1'b1));
    send_cmd(rand_item(CMD_CLEAR, 1'b1));

    // mixed segments, mostly ending in a clear
    while (items_sent - rnd_start < RANDOM_ITEMS) begin
      seg_len = $urandom_range(15, 70);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 32)      send_cmd(rand_item(CMD_ADD_ENTRY, $urandom_range(0, 9) != 0));
        else if (roll < 52) send_cmd(rand_item(CMD_ADD_RANGE, $urandom_range(0, 9) != 0));
        else if (roll < 97) send_cmd(rand_item(CMD_LOOKUP, 1'b1));
        else                send_cmd(rand_item(CMD_CLEAR, 1'b1));
      end
      if ($urandom_range(0, 3) != 0) send_cmd(rand_item(CMD_CLEAR, 1'b1));
    end
    in_if.valid <= 1'b0;

    // drain: pending is a registered copy of the expected-result queue size
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: code_to_unicode_map_table.f
src/ctum_pkg.sv
src/ctum_in_if.sv
src/ctum_out_if.sv
src/ctum_entry_store.sv
src/ctum_range_store.sv
src/code_to_unicode_map_table.sv
src/ctum_checker.sv
sim/ctum_checker.sv
sim/testbench.sv
